/* rtl/indexed_pixel_clut_expander_macros.svh */
// assertion macros for the colour lookup expander
// needs nothing else; included by files that carry concurrent checks
`ifndef INDEXED_PIXEL_CLUT_EXPANDER_MACROS_SVH
`define INDEXED_PIXEL_CLUT_EXPANDER_MACROS_SVH

// antecedent implies consequent in the next cycle
`define IPCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: label");

// condition must never hold
`define IPCE_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("check failed: label");

`endif

/* rtl/ipce_pkg.sv */
// shared types, codes and index mapping for the colour lookup expander
// no dependencies
package ipce_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ARGB_W        = 32;
  localparam int BUF_DEPTH     = 4;
  localparam int BUF_PTR_W     = $clog2(BUF_DEPTH);
  localparam int BUF_CNT_W     = BUF_PTR_W + 1;

  // input beat kinds
  localparam logic [1:0] OP_SET_INDEX = 2'd0;
  localparam logic [1:0] OP_COLOUR    = 2'd1;
  localparam logic [1:0] OP_EXPAND    = 2'd2;

  // depth codes
  localparam logic [1:0] DEPTH_1BPP = 2'd0;
  localparam logic [1:0] DEPTH_2BPP = 2'd1;
  localparam logic [1:0] DEPTH_4BPP = 2'd2;
  localparam logic [1:0] DEPTH_8BPP = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] IDX_1BPP_SET = 8'd255;
  localparam logic [7:0] IDX_1BPP_CLR = 8'd127;

  // table write request from the loader
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [ARGB_W-1:0] data;
  } tbl_wr_t;

  // table read request from the expander
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] addr;
    logic             last;
  } tbl_rd_t;

  // table index of the most significant pixel of a byte
  function automatic logic [IDX_W-1:0] pixel_index(input logic [1:0] depth,
                                                   input logic [7:0] pix);
    logic [IDX_W-1:0] idx;
    case (depth)
      DEPTH_1BPP: idx = pix[7] ? IDX_1BPP_SET : IDX_1BPP_CLR;
      DEPTH_2BPP: idx = {pix[7:6], 6'h3F};
      DEPTH_4BPP: idx = {pix[7:4], 4'hF};
      default:    idx = pix;
    endcase
    return idx;
  endfunction

  // pixels per byte minus one
  function automatic logic [2:0] last_pixel(input logic [1:0] depth);
    logic [2:0] n;
    case (depth)
      DEPTH_1BPP: n = 3'd7;
      DEPTH_2BPP: n = 3'd3;
      DEPTH_4BPP: n = 3'd1;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/ipce_loader.sv */
// table loader: pointer, component count and held red/green bytes
// depends on ipce_pkg
module ipce_loader (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat,
  input  logic [1:0]       opcode,
  input  logic [7:0]       data_byte,
  output ipce_pkg::tbl_wr_t wr
);
  import ipce_pkg::*;

  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [7:0]       red_r, red_nxt;
  logic [7:0]       green_r, green_nxt;

  // decode one beat
  always_comb begin
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    wr.en     = 1'b0;
    wr.addr   = ptr_r;
    wr.data   = {ALPHA_OPAQUE, red_r, green_r, data_byte};
    if (beat) begin
      case (opcode)
        OP_SET_INDEX: begin
          ptr_nxt = data_byte;
          cnt_nxt = 2'd0;
        end
        OP_COLOUR: begin
          if (cnt_r[1]) begin
            wr.en   = 1'b1;
            ptr_nxt = ptr_r + 1'b1;
            cnt_nxt = 2'd0;
          end else begin
            if (cnt_r[0]) green_nxt = data_byte;
            else          red_nxt   = data_byte;
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      cnt_r   <= 2'd0;
      red_r   <= 8'd0;
      green_r <= 8'd0;
    end else begin
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
    end
  end

endmodule

/* rtl/ipce_expander.sv */
// pixel sequencer: walks a byte msb first, one table read a cycle with credit
// depends on ipce_pkg
module ipce_expander (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [7:0]        pix_byte,
  input  logic [1:0]        depth,
  input  logic              credit_ok,
  output logic              can_take,
  output ipce_pkg::tbl_rd_t rd
);
  import ipce_pkg::*;

  logic       busy_r, busy_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] depth_r, depth_nxt;
  logic [2:0] remain_r, remain_nxt;
  logic       issue;

  assign issue    = busy_r && credit_ok;
  assign rd.valid = issue;
  assign rd.addr  = pixel_index(depth_r, byte_r);
  assign rd.last  = (remain_r == 3'd0);
  assign can_take = !busy_r || (issue && rd.last);

  // next pixel state
  always_comb begin
    busy_nxt   = busy_r;
    byte_nxt   = byte_r;
    depth_nxt  = depth_r;
    remain_nxt = remain_r;
    if (start) begin
      busy_nxt   = 1'b1;
      byte_nxt   = pix_byte;
      depth_nxt  = depth;
      remain_nxt = last_pixel(depth);
    end else if (issue) begin
      if (rd.last) begin
        busy_nxt = 1'b0;
      end else begin
        remain_nxt = remain_r - 3'd1;
        case (depth_r)
          DEPTH_1BPP: byte_nxt = {byte_r[6:0], 1'b0};
          DEPTH_2BPP: byte_nxt = {byte_r[5:0], 2'b0};
          DEPTH_4BPP: byte_nxt = {byte_r[3:0], 4'b0};
          default:    byte_nxt = byte_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      remain_r <= 3'd0;
      depth_r  <= DEPTH_8BPP;
    end else begin
      busy_r   <= busy_nxt;
      remain_r <= remain_nxt;
      depth_r  <= depth_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

/* rtl/ipce_clut.sv */
// colour table memory, one write and one registered read per cycle
// depends on ipce_pkg
module ipce_clut (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ipce_pkg::tbl_wr_t           wr,
  input  ipce_pkg::tbl_rd_t           rd,
  output logic                        rd_valid_r,
  output logic                        rd_last_r,
  output logic [ipce_pkg::ARGB_W-1:0] rd_data_r
);
  import ipce_pkg::*;

  logic [ARGB_W-1:0] mem [TABLE_ENTRIES];

  // a read in the cycle of a write to the same entry sees the old colour
  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_data_r <= mem[rd.addr];
    rd_last_r <= rd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_valid_r <= 1'b0;
    else        rd_valid_r <= rd.valid;
  end

endmodule

/* rtl/ipce_outbuf.sv */
// small pixel queue between the table read and the result channel
// depends on ipce_pkg
module ipce_outbuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          push_last,
  input  logic [ipce_pkg::ARGB_W-1:0]   push_data,
  output logic                          tvalid,
  input  logic                          tready,
  output logic [ipce_pkg::ARGB_W-1:0]   tdata,
  output logic                          tlast,
  output logic [ipce_pkg::BUF_CNT_W-1:0] count
);
  import ipce_pkg::*;

  logic [ARGB_W:0]        buf_q [BUF_DEPTH];
  logic [BUF_PTR_W-1:0]   wp_r, rp_r;
  logic [BUF_CNT_W-1:0]   cnt_r;
  logic                   pop;

  assign tvalid = (cnt_r != '0);
  assign pop    = tvalid && tready;
  assign tdata  = buf_q[rp_r][ARGB_W-1:0];
  assign tlast  = buf_q[rp_r][ARGB_W];
  assign count  = cnt_r;

  always_ff @(posedge clk) begin
    if (push) buf_q[wp_r] <= {push_last, push_data};
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/indexed_pixel_clut_expander.sv */
// colour lookup expander: a framebuffer byte gives 8, 4, 2 or 1 pixels at 1, 2,
// 4 or 8 bpp, one table read per cycle on the single read port while the queue
// has room; a pixel passes the expander state, the registered read and the queue
// sustained output is one pixel per cycle while out_tready is high
// reset clears pointer, component count, held bytes, queue; depth resets to 8 bpp
// the table memory is not cleared
module indexed_pixel_clut_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte [7:0]
  input  logic [1:0]  in_tuser,   // opcode [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_argb [31:0]
  output logic        out_tlast,  // last_of_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // depth_code [1:0]
);
  import ipce_pkg::*;
  `include "indexed_pixel_clut_expander_macros.svh"

  logic [1:0]           depth_code_r;
  logic                 in_beat;
  logic                 can_take;
  logic                 credit_ok;
  tbl_wr_t              wr;
  tbl_rd_t              rd;
  logic                 rd_valid_r;
  logic                 rd_last_r;
  logic [ARGB_W-1:0]    rd_data_r;
  logic [BUF_CNT_W-1:0] buf_count;
  logic [BUF_CNT_W:0]   committed;

  // depth register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)                      depth_code_r <= DEPTH_8BPP;
    else if (cfg_valid && cfg_ready) depth_code_r <= cfg_data;
  end

  // accept only once the previous byte has issued its final read
  assign in_tready = can_take;
  assign in_beat   = in_tvalid && in_tready;

  // room in the queue for everything queued or in flight
  assign committed = {1'b0, buf_count} + {{BUF_CNT_W{1'b0}}, rd_valid_r};
  assign credit_ok = committed < (BUF_CNT_W+1)'(BUF_DEPTH);

  ipce_loader u_loader (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (in_beat),
    .opcode    (in_tuser),
    .data_byte (in_tdata),
    .wr        (wr)
  );

  ipce_expander u_expander (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_beat && (in_tuser == OP_EXPAND)),
    .pix_byte  (in_tdata),
    .depth     (depth_code_r),
    .credit_ok (credit_ok),
    .can_take  (can_take),
    .rd        (rd)
  );

  ipce_clut u_clut (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .rd         (rd),
    .rd_valid_r (rd_valid_r),
    .rd_last_r  (rd_last_r),
    .rd_data_r  (rd_data_r)
  );

  ipce_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_valid_r),
    .push_last (rd_last_r),
    .push_data (rd_data_r),
    .tvalid    (out_tvalid),
    .tready    (out_tready),
    .tdata     (out_tdata),
    .tlast     (out_tlast),
    .count     (buf_count)
  );

  // checks
  `IPCE_ASSERT_NEVER(a_no_overflow, rd_valid_r && (buf_count == BUF_CNT_W'(BUF_DEPTH)))
  `IPCE_ASSERT_NEXT(a_read_lands, rd.valid, rd_valid_r)
  `IPCE_ASSERT_NEVER(a_count_range, buf_count > BUF_CNT_W'(BUF_DEPTH))

endmodule
